/* rtl/core/rbsd_pkg.sv */
// Rigid body sleep detector: shared widths, register indexes and sequencer states.
// No dependencies.
package rbsd_pkg;

   localparam int COMP_W       = 16;
   localparam int SQ_W         = 2 * COMP_W;
   localparam int MAG_W        = SQ_W / 2;
   localparam int MOTION_W     = 17;
   localparam int HIST_DEPTH   = 16;
   localparam int HIST_IDX_W   = $clog2(HIST_DEPTH);
   localparam int WIN_W        = 5;
   localparam int THR_W        = 17;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 17;
   localparam int SQRT_CNT_W   = $clog2(MAG_W);
   localparam int REM_W        = MAG_W + 1;

   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LEN      = 2'd0,
      CSR_ALWAYS_STATIC   = 2'd1,
      CSR_SLEEP_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_ROOT   = 6'b000100,
      ST_PUSH   = 6'b001000,
      ST_WSUM   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

/* rtl/core/rbsd_req_if.sv */
// Request channel of the sleep detector: valid/ready and one tick's velocities.
// Depends on rbsd_pkg.
interface rbsd_req_if;
   logic valid;
   logic ready;
   logic signed [rbsd_pkg::COMP_W-1:0] vel_x;
   logic signed [rbsd_pkg::COMP_W-1:0] vel_y;
   logic signed [rbsd_pkg::COMP_W-1:0] vel_z;
   logic signed [rbsd_pkg::COMP_W-1:0] spin_x;
   logic signed [rbsd_pkg::COMP_W-1:0] spin_y;
   logic signed [rbsd_pkg::COMP_W-1:0] spin_z;

   modport source (output valid, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z, input ready);
   modport sink   (input valid, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z, output ready);
endinterface

/* rtl/core/rbsd_rsp_if.sv */
// Response channel of the sleep detector: valid/ready and one tick's result.
// Depends on rbsd_pkg.
interface rbsd_rsp_if;
   logic valid;
   logic ready;
   logic go_to_sleep;
   logic [rbsd_pkg::MOTION_W-1:0] motion_now;
   logic tick_ignored;

   modport source (output valid, go_to_sleep, motion_now, tick_ignored, input ready);
   modport sink   (input valid, go_to_sleep, motion_now, tick_ignored, output ready);
endinterface

/* rtl/core/rigid_body_sleep_detector_unit.sv */
// Rigid body sleep detector top level: squares, two roots, history and weighted sum.
// Each vector's three components are squared and summed, then its square root is taken;
// then a push and the window sum, one entry per cycle over the window length W (1..16).
// An ignored tick skips straight to the response. A new request is accepted only in the
// idle state, after the previous result has been registered for the response.
// Synchronous active-high reset: history cleared, registers to 8 / 0 / 128.
// Depends on rbsd_pkg, rbsd_req_if, rbsd_rsp_if, rbsd_isqrt.
module rigid_body_sleep_detector_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [rbsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbsd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   rbsd_req_if.sink                           req_ch,
   rbsd_rsp_if.source                         rsp_ch
);
   import rbsd_pkg::*;

   state_type            state_ff, state_in;
   logic [WIN_W-1:0]     window_len_ff, window_len_in;
   logic                 always_static_ff, always_static_in;
   logic [THR_W-1:0]     sleep_threshold_ff, sleep_threshold_in;
   logic [MOTION_W-1:0]  hist_ff [HIST_DEPTH];
   logic [MOTION_W-1:0]  hist_in [HIST_DEPTH];
   logic [1:0]           comp_ff, comp_in;
   logic                 vec_ff, vec_in;
   logic [HIST_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [COMP_W-1:0]    field_ff [6];
   logic [COMP_W-1:0]    field_in [6];
   logic [SQ_W-1:0]      acc_ff, acc_in;
   logic [MAG_W-1:0]     mag0_ff, mag0_in;
   logic [MOTION_W-1:0]  motion_ff, motion_in;
   logic [MOTION_W-1:0]  wacc_ff, wacc_in;
   logic                 ignored_ff, ignored_in;
   logic                 go_ff, go_in;
   logic [MOTION_W-1:0]  rsp_motion_ff, rsp_motion_in;
   logic                 rsp_ignored_ff, rsp_ignored_in;

   logic                 req_xfer;
   logic                 out_free;
   logic [WIN_W-1:0]     win;
   logic [2:0]           field_idx;
   logic [COMP_W-1:0]    sel_comp;
   logic [COMP_W-1:0]    abs_comp;
   logic [SQ_W-1:0]      square;
   logic [SQ_W-1:0]      acc_sum;
   logic [MOTION_W:0]    wsum;
   logic                 sq_start;
   logic [MAG_W-1:0]     sq_root;
   sqrt_stat_type        sq_stat;

   rbsd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_sum),
      .root     (sq_root),
      .stat     (sq_stat)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (window_len_ff == '0) begin
         win = WIN_W'(1);
      end else if (window_len_ff > WIN_W'(HIST_DEPTH)) begin
         win = WIN_W'(HIST_DEPTH);
      end else begin
         win = window_len_ff;
      end
   end

   always_comb begin
      field_idx = vec_ff ? (3'd3 + {1'b0, comp_ff}) : {1'b0, comp_ff};
      sel_comp  = field_ff[field_idx];
      abs_comp  = sel_comp[COMP_W-1] ? (~sel_comp + COMP_W'(1)) : sel_comp;
      square    = abs_comp * abs_comp;
      acc_sum   = acc_ff + square;
      wsum      = {1'b0, wacc_ff} + {1'b0, hist_ff[idx_ff]};
   end

   // configuration
   always_comb begin
      window_len_in      = window_len_ff;
      always_static_in   = always_static_ff;
      sleep_threshold_in = sleep_threshold_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LEN:      window_len_in      = csr_wdata[WIN_W-1:0];
            CSR_ALWAYS_STATIC:   always_static_in   = csr_wdata[0];
            CSR_SLEEP_THRESHOLD: sleep_threshold_in = csr_wdata[THR_W-1:0];
            default:             window_len_in      = window_len_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      comp_in        = comp_ff;
      vec_in         = vec_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      field_in       = field_ff;
      acc_in         = acc_ff;
      mag0_in        = mag0_ff;
      motion_in      = motion_ff;
      wacc_in        = wacc_ff;
      ignored_in     = ignored_ff;
      go_in          = go_ff;
      rsp_motion_in  = rsp_motion_ff;
      rsp_ignored_in = rsp_ignored_ff;
      hist_in        = hist_ff;
      sq_start       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               field_in[0] = req_ch.vel_x;
               field_in[1] = req_ch.vel_y;
               field_in[2] = req_ch.vel_z;
               field_in[3] = req_ch.spin_x;
               field_in[4] = req_ch.spin_y;
               field_in[5] = req_ch.spin_z;
               ignored_in  = always_static_ff;
               acc_in      = '0;
               comp_in     = '0;
               vec_in      = 1'b0;
               state_in    = always_static_ff ? ST_DONE : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            acc_in  = acc_sum;
            comp_in = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               sq_start = 1'b1;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sq_stat.done) begin
               if (!vec_ff) begin
                  mag0_in  = sq_root;
                  vec_in   = 1'b1;
                  comp_in  = '0;
                  acc_in   = '0;
                  state_in = ST_SQUARE;
               end else begin
                  motion_in = {1'b0, mag0_ff} + {1'b0, sq_root};
                  state_in  = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            hist_in[0] = motion_ff;
            for (int i = 1; i < HIST_DEPTH; i++) begin
               hist_in[i] = (WIN_W'(i) < win) ? hist_ff[i-1] : '0;
            end
            idx_in   = HIST_IDX_W'(win - WIN_W'(1));
            wacc_in  = '0;
            state_in = ST_WSUM;
         end
         ST_WSUM: begin
            wacc_in = wsum[MOTION_W:1];
            idx_in  = idx_ff - HIST_IDX_W'(1);
            if (idx_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               go_in          = !ignored_ff && (wacc_ff < sleep_threshold_ff);
               rsp_motion_in  = ignored_ff ? '0 : motion_ff;
               rsp_ignored_in = ignored_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         window_len_ff      <= WIN_RESET;
         always_static_ff   <= 1'b0;
         sleep_threshold_ff <= THR_RESET;
         comp_ff            <= '0;
         vec_ff             <= 1'b0;
         idx_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff           <= state_in;
         window_len_ff      <= window_len_in;
         always_static_ff   <= always_static_in;
         sleep_threshold_ff <= sleep_threshold_in;
         comp_ff            <= comp_in;
         vec_ff             <= vec_in;
         idx_ff             <= idx_in;
         rsp_valid_ff       <= rsp_valid_in;
         hist_ff            <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      field_ff       <= field_in;
      acc_ff         <= acc_in;
      mag0_ff        <= mag0_in;
      motion_ff      <= motion_in;
      wacc_ff        <= wacc_in;
      ignored_ff     <= ignored_in;
      go_ff          <= go_in;
      rsp_motion_ff  <= rsp_motion_in;
      rsp_ignored_ff <= rsp_ignored_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.go_to_sleep  = go_ff;
   assign rsp_ch.motion_now   = rsp_motion_ff;
   assign rsp_ch.tick_ignored = rsp_ignored_ff;

`ifndef ASSERT_OFF
   a_done_in_root: assert property (@(posedge clock) disable iff (reset)
      sq_stat.done |-> (state_ff == ST_ROOT))
      else $error("root done outside root wait");

   a_idle_sqrt_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !sq_stat.busy)
      else $error("square root busy while accepting");

   a_wsum_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WSUM) |-> ({1'b0, idx_ff} < win))
      else $error("weighted sum index past window");

   a_static_skips: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && always_static_ff) |=> (state_ff == ST_DONE))
      else $error("ignored tick entered the datapath");
`endif

endmodule

/* rtl/core/rbsd_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
// Depends on rbsd_pkg.
module rbsd_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rbsd_pkg::SQ_W-1:0]   radicand,
   output logic [rbsd_pkg::MAG_W-1:0]  root,
   output rbsd_pkg::sqrt_stat_type     stat
);
   import rbsd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]       rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [MAG_W-1:0]      root_ff, root_in;
   logic [REM_W+1:0]      rem_sh;
   logic [REM_W+1:0]      trial;
   logic                  fits;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = (rem_sh >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         cnt_in = cnt_ff + SQRT_CNT_W'(1);
         if (fits) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[MAG_W-2:0], 1'b0};
         end
         if (cnt_ff == SQRT_CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* tb/sv/rigid_body_sleep_detector_unit_test.sv */
// Self-checking bench for rigid_body_sleep_detector_unit: a queued driver with bursty valid,
// a patterned response stall, and an in-bench model of motion history and weighted sleep test.
// Depends on rbsd_pkg, rbsd_req_if, rbsd_rsp_if and the RTL top level.
module rigid_body_sleep_detector_unit_test;
   import rbsd_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 64;
   localparam int TICKS_PER_RUN = 102;
   localparam int RANDOM_RUNS   = 13;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_CSR   = 2'd1,
      OP_DRAIN = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type                kind;
      logic signed [COMP_W-1:0]   vel_x;
      logic signed [COMP_W-1:0]   vel_y;
      logic signed [COMP_W-1:0]   vel_z;
      logic signed [COMP_W-1:0]   spin_x;
      logic signed [COMP_W-1:0]   spin_y;
      logic signed [COMP_W-1:0]   spin_z;
      csr_index_type              reg_idx;
      logic [CSR_DATA_W-1:0]      reg_val;
   } tick_job_type;

   typedef struct packed {
      logic                  sleep;
      logic [MOTION_W-1:0]   motion;
      logic                  ignored;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   rbsd_req_if req_ch ();
   rbsd_rsp_if rsp_ch ();

   rigid_body_sleep_detector_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   tick_job_type  job_queue[$];
   verdict_type   verdict_queue[$];
   int            fault_count = 0;

   // model state
   logic [WIN_W-1:0]      model_window;
   logic                  model_static;
   logic [THR_W-1:0]      model_threshold;
   logic [MOTION_W-1:0]   motion_log [HIST_DEPTH];

   // driver / receiver state
   logic          tick_sent = 1'b0;
   int            gap_left = 0;
   int            burst_left = 1;
   int            quiet_cycles = 0;
   logic          steady = 1'b0;
   logic [15:0]   stall_pattern = 16'hFFFF;
   int            pattern_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [MAG_W-1:0] vector_length(logic signed [COMP_W-1:0] a,
                                                      logic signed [COMP_W-1:0] b,
                                                      logic signed [COMP_W-1:0] c);
      longint sa;
      longint sb;
      longint sc;
      longint sq;
      longint trial;
      logic [MAG_W-1:0] root;
      sa = a;
      sb = b;
      sc = c;
      sq = sa * sa + sb * sb + sc * sc;
      root = '0;
      for (int k = MAG_W - 1; k >= 0; k--) begin
         trial = longint'(root) | (longint'(1) << k);
         if (trial * trial <= sq)
            root = MAG_W'(trial);
      end
      return root;
   endfunction

   function automatic verdict_type predict_verdict(tick_job_type t);
      verdict_type v;
      int          span;
      longint      acc;
      logic [MOTION_W-1:0] motion;
      if (model_static) begin
         v.sleep   = 1'b0;
         v.motion  = '0;
         v.ignored = 1'b1;
         return v;
      end
      motion = MOTION_W'(vector_length(t.vel_x, t.vel_y, t.vel_z))
             + MOTION_W'(vector_length(t.spin_x, t.spin_y, t.spin_z));
      span = int'(model_window);
      if (span < 1)
         span = 1;
      if (span > HIST_DEPTH)
         span = HIST_DEPTH;
      for (int i = HIST_DEPTH - 1; i > 0; i--)
         motion_log[i] = motion_log[i-1];
      motion_log[0] = motion;
      for (int i = span; i < HIST_DEPTH; i++)
         motion_log[i] = '0;
      acc = 0;
      for (int i = span - 1; i >= 0; i--)
         acc = (acc + motion_log[i]) >>> 1;
      v.sleep   = (acc < longint'(model_threshold));
      v.motion  = motion;
      v.ignored = 1'b0;
      return v;
   endfunction

   function automatic logic signed [COMP_W-1:0] pick_component(int style, int amp);
      case (style)
         0: return COMP_W'(int'($urandom_range(0, 2 * amp)) - amp);
         1: return COMP_W'(int'($urandom_range(0, 128)) - 64);
         2: return COMP_W'($urandom);
         default: return COMP_W'(int'($urandom_range(0, 2)) - 1);
      endcase
   endfunction

   task automatic push_tick(int a, int b, int c, int d, int e, int f);
      tick_job_type j;
      j = '0;
      j.kind   = OP_TICK;
      j.vel_x  = COMP_W'(a);
      j.vel_y  = COMP_W'(b);
      j.vel_z  = COMP_W'(c);
      j.spin_x = COMP_W'(d);
      j.spin_y = COMP_W'(e);
      j.spin_z = COMP_W'(f);
      job_queue.push_back(j);
   endtask

   task automatic push_csr(csr_index_type idx, int val);
      tick_job_type j;
      j = '0;
      j.kind    = OP_CSR;
      j.reg_idx = idx;
      j.reg_val = CSR_DATA_W'(val);
      job_queue.push_back(j);
   endtask

   task automatic push_drain();
      tick_job_type j;
      j = '0;
      j.kind = OP_DRAIN;
      job_queue.push_back(j);
   endtask

   task automatic push_random_run(int run);
      int style;
      int seg_left;
      int amp;
      style = 0;
      seg_left = 0;
      amp = 0;
      for (int n = 0; n < TICKS_PER_RUN; n++) begin
         if (n == TICKS_PER_RUN / 2 && run % 4 == 1)
            push_drain();
         if (seg_left == 0) begin
            seg_left = $urandom_range(5, 25);
            style = $urandom_range(0, 9);
            style = (style < 5) ? 0 : (style < 7) ? 1 : (style < 9) ? 2 : 3;
            amp = $urandom_range(0, 4096);
         end
         push_tick(pick_component(style, amp), pick_component(style, amp),
                   pick_component(style, amp), pick_component(style, amp),
                   pick_component(style, amp), pick_component(style, amp));
         amp = amp / 2 + $urandom_range(0, 1);
         seg_left--;
      end
   endtask

   // driver: one job per step, outputs change at the falling edge
   always @(negedge clock) begin : drive_jobs
      tick_job_type head;
      logic nxt_valid;
      logic nxt_csr;
      nxt_valid = req_ch.valid;
      nxt_csr   = 1'b0;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (req_ch.valid && !tick_sent) begin
         nxt_valid = 1'b1;
      end else begin
         nxt_valid = 1'b0;
         if (verdict_queue.size() == 0 && !tick_sent)
            quiet_cycles++;
         else
            quiet_cycles = 0;
         if (job_queue.size() != 0) begin
            head = job_queue[0];
            case (head.kind)
               OP_TICK: begin
                  if (gap_left != 0) begin
                     gap_left--;
                  end else begin
                     void'(job_queue.pop_front());
                     nxt_valid = 1'b1;
                     req_ch.vel_x  <= head.vel_x;
                     req_ch.vel_y  <= head.vel_y;
                     req_ch.vel_z  <= head.vel_z;
                     req_ch.spin_x <= head.spin_x;
                     req_ch.spin_y <= head.spin_y;
                     req_ch.spin_z <= head.spin_z;
                     if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = steady ? 0 : $urandom_range(0, 7);
                     end else begin
                        burst_left--;
                     end
                  end
               end
               OP_CSR: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     void'(job_queue.pop_front());
                     nxt_csr = 1'b1;
                     csr_index <= head.reg_idx;
                     csr_wdata <= head.reg_val;
                     quiet_cycles = 0;
                     steady = ($urandom_range(0, 3) == 0);
                  end
               end
               default: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     void'(job_queue.pop_front());
                     steady = ($urandom_range(0, 3) == 0);
                  end
               end
            endcase
         end
      end
      req_ch.valid <= nxt_valid;
      csr_wr_en <= nxt_csr;
   end

   always @(negedge clock) begin : pace_results
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(16, 80);
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      pattern_left--;
      rsp_ch.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   always @(posedge clock) begin : watch_ports
      verdict_type want;
      tick_job_type seen;
      tick_sent <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_WINDOW_LEN:      model_window    = csr_wdata[WIN_W-1:0];
               CSR_ALWAYS_STATIC:   model_static    = csr_wdata[0];
               CSR_SLEEP_THRESHOLD: model_threshold = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            seen = '0;
            seen.vel_x  = req_ch.vel_x;
            seen.vel_y  = req_ch.vel_y;
            seen.vel_z  = req_ch.vel_z;
            seen.spin_x = req_ch.spin_x;
            seen.spin_y = req_ch.spin_y;
            seen.spin_z = req_ch.spin_z;
            verdict_queue.push_back(predict_verdict(seen));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected response transfer sleep=%0b motion=%0d ignored=%0b",
                        $time, rsp_ch.go_to_sleep, rsp_ch.motion_now, rsp_ch.tick_ignored);
               fault_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_ch.go_to_sleep !== want.sleep) begin
                  $display("%0t: go_to_sleep expected %0b actual %0b",
                           $time, want.sleep, rsp_ch.go_to_sleep);
                  fault_count++;
               end
               if (rsp_ch.motion_now !== want.motion) begin
                  $display("%0t: motion_now expected %0d actual %0d",
                           $time, want.motion, rsp_ch.motion_now);
                  fault_count++;
               end
               if (rsp_ch.tick_ignored !== want.ignored) begin
                  $display("%0t: tick_ignored expected %0b actual %0b",
                           $time, want.ignored, rsp_ch.tick_ignored);
                  fault_count++;
               end
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.vel_x  = '0;
      req_ch.vel_y  = '0;
      req_ch.vel_z  = '0;
      req_ch.spin_x = '0;
      req_ch.spin_y = '0;
      req_ch.spin_z = '0;
      rsp_ch.ready  = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      model_window    = WIN_RESET;
      model_static    = 1'b0;
      model_threshold = THR_RESET;
      for (int i = 0; i < HIST_DEPTH; i++)
         motion_log[i] = '0;

      // directed: field extremes at reset settings
      push_tick(0, 0, 0, 0, 0, 0);
      push_tick(32767, 32767, 32767, 32767, 32767, 32767);
      push_tick(-32768, -32768, -32768, -32768, -32768, -32768);
      push_tick(32767, -32768, 32767, -32768, 32767, -32768);
      push_tick(-32768, 0, 0, 0, 0, 0);
      push_tick(0, 0, 0, 0, 0, 32767);
      push_tick(1, 1, 1, -1, -1, -1);
      push_tick(256, 0, 0, 0, 256, 0);
      push_tick(0, 0, 0, 0, 0, 0);
      // static body: history must survive untouched
      push_csr(CSR_ALWAYS_STATIC, 1);
      push_tick(32767, 32767, 32767, 32767, 32767, 32767);
      push_tick(0, 0, 0, 0, 0, 0);
      push_csr(CSR_ALWAYS_STATIC, 0);
      push_tick(0, 0, 0, 0, 0, 0);
      // window and threshold extremes, out-of-range windows
      push_csr(CSR_WINDOW_LEN, 1);
      push_csr(CSR_SLEEP_THRESHOLD, 0);
      push_tick(0, 0, 0, 0, 0, 0);
      push_tick(3, 4, 0, 0, 0, 0);
      push_csr(CSR_WINDOW_LEN, 16);
      push_csr(CSR_SLEEP_THRESHOLD, 131071);
      push_tick(32767, 32767, 32767, 32767, 32767, 32767);
      push_tick(-32768, -32768, -32768, -32768, -32768, -32768);
      push_csr(CSR_WINDOW_LEN, 0);
      push_csr(CSR_SLEEP_THRESHOLD, 1);
      push_tick(0, 0, 0, 0, 0, 1);
      push_tick(0, 0, 0, 0, 0, 0);
      push_csr(CSR_WINDOW_LEN, 17);
      push_csr(CSR_SLEEP_THRESHOLD, 300);
      push_tick(100, 0, 0, 0, 0, 0);
      push_tick(0, 0, 0, 0, 0, 0);
      push_csr(CSR_WINDOW_LEN, 31);
      push_tick(0, 0, 0, 0, 0, 0);
      push_tick(0, 0, 0, 0, 0, 0);
      push_drain();

      for (int run = 0; run < RANDOM_RUNS; run++) begin
         case ($urandom_range(0, 7))
            0: push_csr(CSR_WINDOW_LEN, $urandom_range(17, 31));
            1: push_csr(CSR_WINDOW_LEN, 0);
            default: push_csr(CSR_WINDOW_LEN, $urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 4))
            0: push_csr(CSR_SLEEP_THRESHOLD, $urandom_range(0, 256));
            1: push_csr(CSR_SLEEP_THRESHOLD, $urandom_range(0, 4096));
            2: push_csr(CSR_SLEEP_THRESHOLD, $urandom & 32'h1FFFF);
            3: push_csr(CSR_SLEEP_THRESHOLD, (run % 2) ? 131071 : 0);
            default: push_csr(CSR_SLEEP_THRESHOLD, $urandom_range(64, 1024));
         endcase
         push_csr(CSR_ALWAYS_STATIC, (run % 6 == 5) ? 1 : 0);
         push_random_run(run);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (job_queue.size() != 0 || verdict_queue.size() != 0 || req_ch.valid)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fault_count == 0 && verdict_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/rbsd_pkg.sv
rtl/core/rbsd_req_if.sv
rtl/core/rbsd_rsp_if.sv
rtl/core/rbsd_isqrt.sv
rtl/core/rigid_body_sleep_detector_unit.sv
tb/sv/rigid_body_sleep_detector_unit_test.sv
